// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int ENTRY_CNT_W = 5;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } entry_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        entry_t entry;
        logic   keep;
    } link_t;

    // Broadcast to every cell in the cycle an item is accepted.
    typedef struct packed {
        logic   insert;
        logic   shift_up;
        entry_t entry;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/spq_req_if.sv -----
// Request channel: valid/ready plus the operation payload.
`default_nettype none
interface spq_req_if;
    logic                                       valid;
    logic                                       ready;
    logic [1:0]                                 action;
    logic signed [spq_pkg::VALUE_W-1:0]         item_value;
    logic        [spq_pkg::PRIO_W-1:0]          item_priority;

    modport source (output valid, output action, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input action, input item_value, input item_priority,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/spq_rsp_if.sv -----
// Response channel: valid/ready plus the result payload.
`default_nettype none
interface spq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic signed [spq_pkg::VALUE_W-1:0]     out_value;
    logic        [spq_pkg::PRIO_W-1:0]      out_priority;
    logic [spq_pkg::ENTRY_CNT_W-1:0]        entry_count;
    logic                                   is_empty_now;

    modport source (output valid, output status, output out_value, output out_priority,
                    output entry_count, output is_empty_now, input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                    input entry_count, input is_empty_now, output ready);
endinterface
`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One slot of the sorted shift register: holds an entry, inserts, shifts.
`default_nettype none
module spq_cell (
    input  wire logic            clk,
    input  wire spq_pkg::cmd_t   cmd,
    input  wire logic            occupied,
    input  wire spq_pkg::link_t  prev_link,
    input  wire spq_pkg::entry_t next_entry,
    output spq_pkg::link_t       link
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            keep;

    // Stay put when holding an entry that outranks or ties the new one.
    assign keep = occupied && (entry_reg.prio >= cmd.entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert && !keep)
        begin
            if (prev_link.keep)
                entry_next = cmd.entry;
            else
                entry_next = prev_link.entry;
        end
        else if (cmd.shift_up)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.entry = entry_reg;
    assign link.keep  = keep;

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue_top.sv -----
// Sorted priority queue: a row of slot cells with head at slot zero.
// The result beat is registered and presented in the cycle after the request beat is accepted.
// Throughput: one operation per cycle while each response beat is taken; every cell
// compares and shifts in the same cycle, whatever the row width.
// Reset clears the entry count and the response valid; slot contents are
// left as they are and are never read before being written.
`default_nettype none
module sorted_priority_queue_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW    = spq_pkg::COUNT_W;

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            rsp_valid_reg;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    spq_pkg::entry_t head_out_reg;
    spq_pkg::entry_t head_out_next;

    logic            fire;
    logic            is_full;
    logic            no_entries;
    spq_pkg::cmd_t   cmd;
    spq_pkg::link_t  links [DEPTH];
    logic [DEPTH-1:0] occupied;
    logic [CW+spq_pkg::ENTRY_CNT_W-1:0] count_wide;

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign fire       = req.valid && req.ready;
    assign is_full    = (count_reg == CW'(DEPTH));
    assign no_entries = (count_reg == '0);

    always_comb
    begin
        cmd.insert       = 1'b0;
        cmd.shift_up     = 1'b0;
        cmd.entry.value  = req.item_value;
        cmd.entry.prio   = req.item_priority;
        count_next       = count_reg;
        status_next      = spq_pkg::ST_DONE;
        head_out_next    = '0;
        case (req.action)
            spq_pkg::ACT_ENQUEUE:
            begin
                if (is_full)
                    status_next = spq_pkg::ST_FULL;
                else
                begin
                    cmd.insert = fire;
                    count_next = count_reg + CW'(1);
                end
            end
            spq_pkg::ACT_DEQUEUE, spq_pkg::ACT_PEEK:
            begin
                if (no_entries)
                    status_next = spq_pkg::ST_EMPTY;
                else
                begin
                    head_out_next = links[0].entry;
                    if (req.action == spq_pkg::ACT_DEQUEUE)
                    begin
                        cmd.shift_up = fire;
                        count_next   = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_DONE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            spq_pkg::link_t  prev_link;
            spq_pkg::entry_t next_entry;

            assign occupied[i] = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_link.entry = '0;
                assign prev_link.keep  = 1'b1;
            end
            else
            begin : g_body
                assign prev_link = links[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_entry = '0;
            end
            else
            begin : g_mid
                assign next_entry = links[i+1].entry;
            end

            spq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occupied[i]),
                .prev_link  (prev_link),
                .next_entry (next_entry),
                .link       (links[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                count_reg <= count_next;
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the response payload until the beat is taken.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_next;
            head_out_reg <= head_out_next;
        end
    end

    assign count_wide       = {{spq_pkg::ENTRY_CNT_W{1'b0}}, count_reg};
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_value    = head_out_reg.value;
    assign rsp.out_priority = head_out_reg.prio;
    assign rsp.entry_count  = count_wide[spq_pkg::ENTRY_CNT_W-1:0];
    assign rsp.is_empty_now = no_entries;

    // The response always reports the count as it stands after its operation.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above queue depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.action == spq_pkg::ACT_ENQUEUE && !is_full
        |=> count_reg == $past(count_reg) + CW'(1) && status_reg == spq_pkg::ST_DONE)
        else $error("accepted enqueue did not add an entry");

    a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.action == spq_pkg::ACT_DEQUEUE && no_entries
        |=> status_reg == spq_pkg::ST_EMPTY && head_out_reg == '0 && count_reg == '0)
        else $error("dequeue on empty queue misreported");

    generate
        for (i = 0; i < DEPTH - 1; i++)
        begin : g_order_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                occupied[i+1] |-> links[i].entry.prio >= links[i+1].entry.prio)
                else $error("slots out of priority order");
        end
    endgenerate

endmodule
`default_nettype wire
